[hw/rtl/srts_pkg.sv]
// ----------------------------------------------------------------------------
// srts_pkg
// Shared constants for the step-rate to timer settings block: register
// indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package srts_pkg;

	localparam int unsigned CfgIdxW   = 2;
	localparam int unsigned CfgDataW  = 32;
	localparam int unsigned OutTdataW = 56;

	localparam logic [CfgIdxW-1:0] REG_TMR_SRC_HZ      = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_PRESCALER_LIMIT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_PERIOD_LIMIT    = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_PULSE_WIDTH_US  = 2'd3;

	localparam logic [31:0] RST_TMR_SRC_HZ      = 32'd84000000;
	localparam logic [15:0] RST_PRESCALER_LIMIT = 16'hFFFF;
	localparam logic [15:0] RST_PERIOD_LIMIT    = 16'hFFFF;
	localparam logic [7:0]  RST_PULSE_WIDTH_US  = 8'd5;

	localparam logic [31:0] TICKS_PER_US_DIV = 32'd1000000;

endpackage

[hw/rtl/step_rate_to_timer_settings.sv]
// ----------------------------------------------------------------------------
// step_rate_to_timer_settings
// Turns a requested step frequency into prescaler, period and compare
// settings with one shared radix-2 divider and one 32x17 multiplier.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata[31:0] step_rate_hz
//  m_axis    out  m_axis_tvalid/tready    tdata: prescaler, period, compare, apply
//  cfg       in   cfg_wr_en               cfg_index, cfg_data
//
//  Each prescaler step taken (up to prescaler_limit) costs one multiply and one
//  32-bit division in the shared divider; a period clamp adds another multiply
//  and division, and an applied result adds the tick and microsecond divisions
//  and the compare multiply; the divisions dominate the time taken.
//  A zero frequency skips the divider and goes straight to S_DONE. s_axis_tready
//  is high only while idle; a finished word waits in the output register and
//  the next input may be taken meanwhile. Reset restores config register defaults.
// ----------------------------------------------------------------------------
module step_rate_to_timer_settings
	import srts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,   // [31:0] step_rate_hz
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [15:0] prescaler_value, [31:16] period_value, [47:32] compare_value,
	// [48] apply, [55:49] zero
	output logic [OutTdataW-1:0] m_axis_tdata
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_CHECK,
		S_MUL,
		S_MULCHK,
		S_FINISH,
		S_CMP,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		K_PER,
		K_PRE,
		K_TICK,
		K_US
	} div_kind_t;

	typedef enum logic [1:0] {
		M_LOOP,
		M_CLAMP,
		M_CMP
	} mul_sel_t;

	logic [31:0] tmr_src_hz_q;
	logic [15:0] prescaler_limit_q;
	logic [15:0] period_limit_q;
	logic [7:0]  pulse_width_us_q;

	state_t      state_q;
	div_kind_t   div_kind_q;
	mul_sel_t    mul_sel_q;
	logic [31:0] freq_q;
	logic [31:0] pre_q;
	logic [31:0] per_q;
	logic [31:0] prod_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [4:0]  cnt_q;
	logic [15:0] res_cmp_q;
	logic        res_ok_q;
	logic        out_valid_q;
	logic [OutTdataW-1:0] out_data_q;

	// divider step
	logic [32:0] rem_sh;
	logic        div_ge;
	logic [32:0] rem_nx;
	logic [31:0] quo_nx;

	// multiplier
	logic [31:0] mul_a;
	logic [16:0] mul_b;
	logic [48:0] mul_full;

	logic [31:0] prelim_ext;
	logic [31:0] perlim_ext;
	logic [31:0] pre_c;
	logic [31:0] cmp_raw;
	logic [31:0] cmp_c;

	always_comb begin
		rem_sh = {rem_q, quo_q[31]};
		div_ge = rem_sh >= {1'b0, dsr_q};
		rem_nx = div_ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
		quo_nx = {quo_q[30:0], div_ge};

		case (mul_sel_q)
			M_LOOP: begin
				mul_a = freq_q;
				mul_b = {1'b0, pre_q[15:0]} + 17'd1;
			end
			M_CLAMP: begin
				mul_a = freq_q;
				mul_b = {1'b0, per_q[15:0]};
			end
			M_CMP: begin
				mul_a = quo_q;
				mul_b = {9'd0, pulse_width_us_q};
			end
			default: begin
				mul_a = freq_q;
				mul_b = 17'd0;
			end
		endcase
		mul_full = {17'd0, mul_a} * {32'd0, mul_b};

		prelim_ext = {16'd0, prescaler_limit_q};
		perlim_ext = {16'd0, period_limit_q};
		pre_c      = (pre_q > prelim_ext) ? prelim_ext : pre_q;
		cmp_raw    = (prod_q == 32'd0) ? 32'd1 : prod_q;
		cmp_c      = (cmp_raw > per_q) ? per_q : cmp_raw;
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmr_src_hz_q      <= RST_TMR_SRC_HZ;
			prescaler_limit_q <= RST_PRESCALER_LIMIT;
			period_limit_q    <= RST_PERIOD_LIMIT;
			pulse_width_us_q  <= RST_PULSE_WIDTH_US;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TMR_SRC_HZ:      tmr_src_hz_q      <= cfg_data;
				REG_PRESCALER_LIMIT: prescaler_limit_q <= cfg_data[15:0];
				REG_PERIOD_LIMIT:    period_limit_q    <= cfg_data[15:0];
				REG_PULSE_WIDTH_US:  pulse_width_us_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_kind_q  <= K_PER;
			mul_sel_q   <= M_LOOP;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && state_q != S_DONE)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						freq_q <= s_axis_tdata;
						pre_q  <= 32'd0;
						if (s_axis_tdata == 32'd0) begin
							per_q     <= 32'd0;
							res_cmp_q <= 16'd0;
							res_ok_q  <= 1'b0;
							state_q   <= S_DONE;
						end else begin
							quo_q      <= tmr_src_hz_q;
							rem_q      <= 32'd0;
							dsr_q      <= s_axis_tdata;
							cnt_q      <= 5'd0;
							div_kind_q <= K_PER;
							state_q    <= S_DIV;
						end
					end
				end
				S_DIV: begin
					quo_q <= quo_nx;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31 && div_kind_q == K_TICK)
						rem_q <= 32'd0;
					else
						rem_q <= rem_nx[31:0];
					if (cnt_q == 5'd31) begin
						case (div_kind_q)
							K_PER: begin
								per_q   <= quo_nx;
								state_q <= S_CHECK;
							end
							K_PRE: begin
								pre_q   <= quo_nx - 32'd1;
								state_q <= S_FINISH;
							end
							K_TICK: begin
								// whole ticks per microsecond
								dsr_q      <= TICKS_PER_US_DIV;
								div_kind_q <= K_US;
							end
							K_US: begin
								mul_sel_q <= M_CMP;
								state_q   <= S_MUL;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CHECK: begin
					if (per_q > perlim_ext && pre_q < prelim_ext) begin
						pre_q     <= pre_q + 32'd1;
						mul_sel_q <= M_LOOP;
						state_q   <= S_MUL;
					end else if (per_q > perlim_ext) begin
						per_q     <= perlim_ext;
						mul_sel_q <= M_CLAMP;
						state_q   <= S_MUL;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_MUL: begin
					prod_q  <= mul_full[31:0];
					state_q <= (mul_sel_q == M_CMP) ? S_CMP : S_MULCHK;
				end
				S_MULCHK: begin
					if (prod_q == 32'd0) begin
						pre_q     <= 32'd0;
						per_q     <= 32'd0;
						res_cmp_q <= 16'd0;
						res_ok_q  <= 1'b0;
						state_q   <= S_DONE;
					end else begin
						quo_q      <= tmr_src_hz_q;
						rem_q      <= 32'd0;
						dsr_q      <= prod_q;
						cnt_q      <= 5'd0;
						div_kind_q <= (mul_sel_q == M_LOOP) ? K_PER : K_PRE;
						state_q    <= S_DIV;
					end
				end
				S_FINISH: begin
					pre_q <= pre_c;
					if (!(per_q < perlim_ext && pre_c < prelim_ext)) begin
						res_cmp_q <= 16'd0;
						res_ok_q  <= 1'b0;
						state_q   <= S_DONE;
					end else begin
						quo_q      <= tmr_src_hz_q;
						rem_q      <= 32'd0;
						dsr_q      <= pre_c + 32'd1;
						cnt_q      <= 5'd0;
						div_kind_q <= K_TICK;
						state_q    <= S_DIV;
					end
				end
				S_CMP: begin
					res_cmp_q <= cmp_c[15:0];
					res_ok_q  <= 1'b1;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= {7'd0, res_ok_q, res_cmp_q, per_q[15:0], pre_q[15:0]};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for step_rate_to_timer_settings. Step-rate words are
// pushed through the input stream with random gaps; every accepted word is
// run through a local prescaler/period/compare calculation and the output
// stream is compared field by field against it. Runs over several timer
// configurations, including the register extremes, plus one long output
// stall to back the block up.
// ----------------------------------------------------------------------------
module tb_top
	import srts_pkg::*;
();

	localparam int unsigned WatchdogLimit = 200000;
	localparam int unsigned HoldCycles    = 3000;
	localparam int unsigned MaxRandSteps  = 32;

	typedef struct packed {
		logic [31:0] step_rate;
		logic [15:0] prescaler;
		logic [15:0] period;
		logic [15:0] compare;
		logic        apply;
	} timer_settings_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CfgIdxW-1:0]   cfg_index;
	logic [CfgDataW-1:0]  cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata;   // [31:0] step_rate_hz
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// [15:0] prescaler_value, [31:16] period_value, [47:32] compare_value, [48] apply
	logic [OutTdataW-1:0] m_axis_tdata;

	// shadow of the block's registers
	logic [31:0] tmr_src_hz;
	logic [31:0] presc_limit;
	logic [31:0] period_lim;
	logic [31:0] pulse_us;

	logic [31:0]     rate_queue[$];
	timer_settings_t settings_expected[$];

	int unsigned rates_queued;
	int unsigned results_seen;
	int unsigned mismatch_count;
	int unsigned idle_cycles;
	int unsigned send_gap;
	int unsigned recv_wait;
	int unsigned hold_left;
	int unsigned hold_trigger;
	int unsigned hold_count;
	logic        no_gaps;
	logic        in_fire;
	logic        out_fire;

	step_rate_to_timer_settings uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// prescaler search, period clamp and compare value; all 32-bit wrapping
	function automatic timer_settings_t compute_timer_settings(input logic [31:0] rate,
			output int unsigned steps);
		timer_settings_t r;
		logic [31:0] pre;
		logic [31:0] per;
		logic [31:0] div;
		logic [31:0] tick;
		logic [31:0] cmp;
		r = '0;
		r.step_rate = rate;
		steps = 0;
		if (rate == 32'd0)
			return r;
		pre = 32'd0;
		per = tmr_src_hz / rate;
		while (per > period_lim && pre < presc_limit) begin
			pre = pre + 32'd1;
			steps = steps + 1;
			div = (pre + 32'd1) * rate;
			if (div == 32'd0)
				return r;
			per = tmr_src_hz / div;
		end
		if (per > period_lim) begin
			per = period_lim;
			div = per * rate;
			if (div == 32'd0)
				return r;
			pre = tmr_src_hz / div - 32'd1;
		end
		if (pre > presc_limit)
			pre = presc_limit;
		r.prescaler = pre[15:0];
		r.period = per[15:0];
		if (!(per < period_lim && pre < presc_limit))
			return r;
		tick = tmr_src_hz / (pre + 32'd1);
		cmp = (tick / TICKS_PER_US_DIV) * pulse_us;
		if (cmp == 32'd0)
			cmp = 32'd1;
		if (cmp > per)
			cmp = per;
		r.compare = cmp[15:0];
		r.apply = 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] rate,
			input logic [31:0] got, input logic [31:0] want);
		mismatch_count++;
		$display("mismatch %s: rate %0d got %0d want %0d", what, rate, got, want);
	endtask

	function automatic int unsigned draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 9);
	endfunction

	// sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !in_fire) begin
			end else if (send_gap != 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (rate_queue.size() != 0) begin
				s_axis_tdata <= rate_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				send_gap <= draw_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		int unsigned w;
		if (arst_n) begin
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_count != hold_trigger) begin
				m_axis_tready <= 1'b0;
				hold_left <= HoldCycles;
				hold_count <= hold_trigger;
			end else if (out_fire) begin
				w = draw_gap();
				recv_wait <= w;
				m_axis_tready <= (w == 0);
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
				m_axis_tready <= (recv_wait == 1);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		timer_settings_t want;
		int unsigned n_steps;
		if (!arst_n) begin
			in_fire <= 1'b0;
			out_fire <= 1'b0;
		end else begin
			in_fire <= s_axis_tvalid && s_axis_tready;
			out_fire <= m_axis_tvalid && m_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (settings_expected.size() == 0) begin
					report_mismatch("unexpected word", 32'd0, m_axis_tdata[31:0], 32'd0);
				end else begin
					want = settings_expected.pop_front();
					if (m_axis_tdata[15:0] !== want.prescaler)
						report_mismatch("prescaler", want.step_rate,
							{16'd0, m_axis_tdata[15:0]}, {16'd0, want.prescaler});
					if (m_axis_tdata[31:16] !== want.period)
						report_mismatch("period", want.step_rate,
							{16'd0, m_axis_tdata[31:16]}, {16'd0, want.period});
					if (m_axis_tdata[47:32] !== want.compare)
						report_mismatch("compare", want.step_rate,
							{16'd0, m_axis_tdata[47:32]}, {16'd0, want.compare});
					if (m_axis_tdata[48] !== want.apply)
						report_mismatch("apply", want.step_rate,
							{31'd0, m_axis_tdata[48]}, {31'd0, want.apply});
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				settings_expected.push_back(compute_timer_settings(s_axis_tdata, n_steps));
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WatchdogLimit) begin
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	task automatic write_timer_cfg(input logic [31:0] clk_hz, input logic [15:0] presc,
			input logic [15:0] per_max, input logic [7:0] width_us);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_TMR_SRC_HZ;
		cfg_data <= clk_hz;
		@(negedge clk);
		cfg_index <= REG_PRESCALER_LIMIT;
		cfg_data <= {16'h0, presc};
		@(negedge clk);
		cfg_index <= REG_PERIOD_LIMIT;
		cfg_data <= {16'h0, per_max};
		@(negedge clk);
		cfg_index <= REG_PULSE_WIDTH_US;
		cfg_data <= {24'h0, width_us};
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tmr_src_hz = clk_hz;
		presc_limit = {16'h0, presc};
		period_lim = {16'h0, per_max};
		pulse_us = {24'h0, width_us};
		@(posedge clk);
	endtask

	task automatic queue_rate(input logic [31:0] rate);
		rate_queue.push_back(rate);
		rates_queued++;
	endtask

	task automatic wait_settings_drained();
		do
			@(negedge clk);
		while (results_seen != rates_queued);
		@(posedge clk);
	endtask

	// mostly rates that need a few prescaler steps, some anywhere in the range
	function automatic logic [31:0] draw_step_rate();
		logic [31:0] rate;
		longint unsigned span;
		int unsigned k;
		int unsigned n_steps;
		for (int tries = 0; tries < 16; tries++) begin
			case ($urandom_range(0, 9))
				0: rate = $urandom();
				1: rate = $urandom_range(0, 3);
				2: rate = tmr_src_hz / period_lim + $urandom_range(0, 2) - 1;
				3: rate = tmr_src_hz + $urandom_range(0, 2) - 1;
				default: begin
					k = $urandom_range(0, 24);
					span = longint'(k + 1) * (longint'(period_lim) + 1);
					rate = 32'(tmr_src_hz / span) + $urandom_range(0, 4);
				end
			endcase
			void'(compute_timer_settings(rate, n_steps));
			if (n_steps <= MaxRandSteps)
				return rate;
		end
		return tmr_src_hz;
	endfunction

	initial begin
		logic [31:0] rnd_clk;
		logic [15:0] rnd_presc;
		logic [15:0] rnd_per;
		timer_settings_t left_over;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_TMR_SRC_HZ;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		tmr_src_hz = RST_TMR_SRC_HZ;
		presc_limit = {16'h0, RST_PRESCALER_LIMIT};
		period_lim = {16'h0, RST_PERIOD_LIMIT};
		pulse_us = {24'h0, RST_PULSE_WIDTH_US};
		rates_queued = 0;
		results_seen = 0;
		mismatch_count = 0;
		idle_cycles = 0;
		send_gap = 0;
		recv_wait = 0;
		hold_left = 0;
		hold_trigger = 0;
		hold_count = 0;
		no_gaps = 1'b0;
		in_fire = 1'b0;
		out_fire = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: zero rate, slowest rate, zero period, boundaries
		queue_rate(32'd0);
		queue_rate(32'd1);
		queue_rate(32'hFFFF_FFFF);
		queue_rate(32'h8000_0000);
		queue_rate(32'd84000000);
		queue_rate(32'd84000001);
		queue_rate(32'd1282);
		queue_rate(32'd1000);
		queue_rate(32'h0000_FFFF);
		queue_rate(32'hFFFF_0000);
		wait_settings_drained();

		// top of every register: period lands on the limit, compare capped
		write_timer_cfg(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'd255);
		queue_rate(32'd65537);
		queue_rate(32'd65536);
		queue_rate(32'd65538);
		queue_rate(32'h7FFF_FFFF);
		queue_rate(32'd4096);
		wait_settings_drained();

		// bottom of every register: nothing can be applied
		write_timer_cfg(32'd1, 16'd0, 16'd1, 8'd1);
		queue_rate(32'd1);
		queue_rate(32'd2);
		queue_rate(32'hFFFF_FFFF);
		wait_settings_drained();

		// prescaler hits its limit, period clamped, prescaler recomputed
		write_timer_cfg(32'd84000000, 16'd3, 16'd1000, 8'd10);
		queue_rate(32'd1000);
		queue_rate(32'd30000);
		queue_rate(32'd1);
		wait_settings_drained();

		// sub-MHz tick: compare raised to one
		write_timer_cfg(32'd999999, 16'hFFFF, 16'hFFFF, 8'd200);
		queue_rate(32'd1);
		queue_rate(32'd15);
		wait_settings_drained();

		for (int ph = 0; ph < 7; ph++) begin
			case ($urandom_range(0, 3))
				0: rnd_clk = $urandom();
				1: rnd_clk = $urandom_range(1, 2000000);
				2: rnd_clk = $urandom_range(2000000, 200000000);
				default: rnd_clk = 32'hFFFF_FFFF - $urandom_range(0, 1000);
			endcase
			if (rnd_clk == 32'd0)
				rnd_clk = 32'd1;
			case ($urandom_range(0, 2))
				0: rnd_presc = $urandom_range(0, 65535);
				1: rnd_presc = $urandom_range(0, 16);
				default: rnd_presc = 16'hFFFF;
			endcase
			case ($urandom_range(0, 2))
				0: rnd_per = $urandom_range(1, 65535);
				1: rnd_per = $urandom_range(1, 256);
				default: rnd_per = 16'hFFFF;
			endcase
			write_timer_cfg(rnd_clk, rnd_presc, rnd_per, $urandom_range(1, 255));
			no_gaps = ($urandom_range(0, 3) == 0);
			if (ph == 2)
				hold_trigger++;
			for (int i = 0; i < 38; i++)
				queue_rate(draw_step_rate());
			wait_settings_drained();
		end

		repeat (300) @(posedge clk);
		while (settings_expected.size() != 0) begin
			left_over = settings_expected.pop_front();
			report_mismatch("missing word", left_over.step_rate, 32'd0, 32'd0);
		end
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
